// ===== hw/rtl/quadrature_direction_speed_macros.svh =====
// ---------------------------------------------------------------------------
// quadrature_direction_speed assertion macros
// shared concurrent assertion forms for the encoder decoder checkers
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_DIRECTION_SPEED_MACROS_SVH
`define QUADRATURE_DIRECTION_SPEED_MACROS_SVH

// same-cycle implication
`define QDS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QDS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qds_pkg.sv =====
// ---------------------------------------------------------------------------
// qds_pkg
// types, constants and the gray-code step for the quadrature decoder
// ---------------------------------------------------------------------------
package qds_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 32;
    localparam int TICKS_W   = 16;
    localparam int DEN_W     = TIME_W + TICKS_W;
    localparam int RPS_W     = 26;
    localparam int RPM_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam longint FULL_SPEED = longint'(1000) << FRAC_BITS;
    localparam int     SPEED_W    = $clog2(FULL_SPEED + 1);
    localparam int     CNT_W      = $clog2(SPEED_W);
    localparam int     EXT_W      = (SPEED_W + 6 > RPM_W) ? SPEED_W + 6 : RPM_W;

    localparam logic [SPEED_W-1:0] FULL_VEC = SPEED_W'(FULL_SPEED);
    localparam logic [EXT_W-1:0]   RPS_MAX  = EXT_W'((longint'(1) << RPS_W) - 1);
    localparam logic [EXT_W-1:0]   RPM_MAX  = EXT_W'((longint'(1) << RPM_W) - 1);
    localparam logic [EXT_W-1:0]   RPM_MUL  = EXT_W'(60);

    localparam logic [CFG_IDX_W-1:0] REG_TICKS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SWAP    = CFG_IDX_W'(2);

    localparam logic [TICKS_W-1:0] TICKS_RESET   = TICKS_W'(20);
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = TIME_W'(500);

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_FWD  = 2'd1,
        MOT_BWD  = 2'd2
    } motion_t;

    typedef struct packed {
        logic              level_a;
        logic              level_b;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic             moving;
        logic             dir_forward;
        logic             dir_backward;
        logic [RPS_W-1:0] rev_per_sec;
        logic [RPM_W-1:0] rev_per_min;
    } result_t;

    // forward is 11 > 01 > 00 > 10 > 11 (a then b)
    function automatic motion_t next_motion(
        input logic [1:0] p,
        input logic [1:0] c,
        input motion_t    old
    );
        motion_t m;
        m = old;
        unique case (p)
            2'b11:
            begin
                if (c == 2'b01) m = MOT_FWD;
                else if (c == 2'b10) m = MOT_BWD;
            end
            2'b10:
            begin
                if (c == 2'b11) m = MOT_FWD;
                else if (c == 2'b00) m = MOT_BWD;
            end
            2'b01:
            begin
                if (c == 2'b00) m = MOT_FWD;
                else if (c == 2'b11) m = MOT_BWD;
            end
            default:
            begin
                if (c == 2'b10) m = MOT_FWD;
                else if (c == 2'b01) m = MOT_BWD;
            end
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/quadrature_direction_speed.sv =====
// ---------------------------------------------------------------------------
// quadrature_direction_speed
// quadrature encoder decoder: direction from the gray-code step, speed in
// unsigned q16 revolutions per second and per minute, stop after a timeout
// ---------------------------------------------------------------------------
// Every sample word gives exactly one result word. A sample with no line
// change passes through the done state into the output register, and the
// sample side is ready again in the same cycle that its answer appears. A
// sample with a change passes through the divider: the interval times ticks
// product is registered, a restoring divider produces one quotient bit per
// cycle, the quotient is taken into the speed register and then the output
// register is loaded. When the product is zero the division steps are
// skipped and the quotient saturates at full scale. The sample side is not
// ready while a word is in work; a finished result waits in the output
// register while the next sample is taken, and a result that cannot be
// handed over because the previous one is still held stalls the block.
// Register writes are expected only while the block is idle.
module quadrature_direction_speed (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  qds_pkg::sample_t                  sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output qds_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [qds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qds_pkg::CFG_W-1:0]         cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [qds_pkg::TICKS_W-1:0]     ticks_reg;
    logic [qds_pkg::TIME_W-1:0]      timeout_reg;
    logic                            swap_reg;
    logic                            prev_a_reg, prev_a_next;
    logic                            prev_b_reg, prev_b_next;
    qds_pkg::motion_t                motion_reg, motion_next;
    logic [qds_pkg::TIME_W-1:0]      last_reg, last_next;
    logic [qds_pkg::SPEED_W-1:0]     speed_reg, speed_next;
    logic                            result_valid_reg, result_valid_next;
    qds_pkg::result_t                result_reg, result_next;

    logic                            accept;
    logic                            changed;
    logic [qds_pkg::TIME_W-1:0]      elapsed;
    logic                            div_start;
    logic                            div_done;
    logic [qds_pkg::SPEED_W-1:0]     div_quo;
    logic                            fwd, bwd;
    logic [qds_pkg::EXT_W-1:0]       speed_ext;
    logic [qds_pkg::EXT_W-1:0]       rpm_full;
    qds_pkg::result_t                result_new;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign changed      = (sample.level_a != prev_a_reg) || (sample.level_b != prev_b_reg);
    assign elapsed      = sample.now_ms - last_reg;

    qds_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .elapsed  (elapsed),
        .ticks    (ticks_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result formatting with swap and saturation
    always_comb
    begin
        fwd       = (motion_reg == qds_pkg::MOT_FWD);
        bwd       = (motion_reg == qds_pkg::MOT_BWD);
        speed_ext = qds_pkg::EXT_W'(speed_reg);
        rpm_full  = speed_ext * qds_pkg::RPM_MUL;
        result_new.moving       = (motion_reg != qds_pkg::MOT_STOP);
        result_new.dir_forward  = swap_reg ? bwd : fwd;
        result_new.dir_backward = swap_reg ? fwd : bwd;
        result_new.rev_per_sec  = (speed_ext > qds_pkg::RPS_MAX)
                                  ? '1 : speed_ext[qds_pkg::RPS_W-1:0];
        result_new.rev_per_min  = (rpm_full > qds_pkg::RPM_MAX)
                                  ? '1 : rpm_full[qds_pkg::RPM_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        prev_a_next       = prev_a_reg;
        prev_b_next       = prev_b_reg;
        motion_next       = motion_reg;
        last_next         = last_reg;
        speed_next        = speed_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        div_start         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_a_next = sample.level_a;
                    prev_b_next = sample.level_b;
                    if (!changed)
                    begin
                        if (elapsed > timeout_reg)
                        begin
                            motion_next = qds_pkg::MOT_STOP;
                            speed_next  = '0;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        motion_next = qds_pkg::next_motion({prev_a_reg, prev_b_reg},
                                                           {sample.level_a, sample.level_b},
                                                           motion_reg);
                        last_next   = sample.now_ms;
                        div_start   = 1'b1;
                        state_next  = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                if (div_done)
                begin
                    speed_next = div_quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next       = result_new;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ticks_reg        <= qds_pkg::TICKS_RESET;
            timeout_reg      <= qds_pkg::TIMEOUT_RESET;
            swap_reg         <= 1'b0;
            prev_a_reg       <= 1'b0;
            prev_b_reg       <= 1'b0;
            motion_reg       <= qds_pkg::MOT_STOP;
            last_reg         <= '0;
            speed_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_a_reg       <= prev_a_next;
            prev_b_reg       <= prev_b_next;
            motion_reg       <= motion_next;
            last_reg         <= last_next;
            speed_reg        <= speed_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    qds_pkg::REG_TICKS:   ticks_reg   <= cfg_data[qds_pkg::TICKS_W-1:0];
                    qds_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[qds_pkg::TIME_W-1:0];
                    qds_pkg::REG_SWAP:    swap_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/qds_divider.sv =====
// ---------------------------------------------------------------------------
// qds_divider
// multiplies interval by ticks, then restoring division of the full-scale
// speed constant by that product, one quotient bit per cycle
// ---------------------------------------------------------------------------
module qds_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [qds_pkg::TIME_W-1:0]       elapsed,
    input  logic [qds_pkg::TICKS_W-1:0]      ticks,
    output logic                             done,
    output logic [qds_pkg::SPEED_W-1:0]      quotient
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_MUL  = 3'b010,
        D_DIV  = 3'b100
    } dstate_t;

    dstate_t                         state_reg, state_next;
    logic [qds_pkg::TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic [qds_pkg::TICKS_W-1:0]     ticks_reg, ticks_next;
    logic [qds_pkg::DEN_W-1:0]       den_reg, den_next;
    logic [qds_pkg::DEN_W-1:0]       rem_reg, rem_next;
    logic [qds_pkg::SPEED_W-1:0]     quo_reg, quo_next;
    logic [qds_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    logic [qds_pkg::DEN_W:0]         trial;
    logic [qds_pkg::DEN_W:0]         den_ext;

    assign trial   = {rem_reg, qds_pkg::FULL_VEC[cnt_reg]};
    assign den_ext = {1'b0, den_reg};

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        ticks_next   = ticks_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    elapsed_next = elapsed;
                    ticks_next   = ticks;
                    state_next   = D_MUL;
                end
            end
            D_MUL:
            begin
                den_next   = qds_pkg::DEN_W'(elapsed_reg) * qds_pkg::DEN_W'(ticks_reg);
                rem_next   = '0;
                cnt_next   = qds_pkg::CNT_W'(qds_pkg::SPEED_W - 1);
                state_next = D_DIV;
            end
            D_DIV:
            begin
                if (den_reg == '0)
                begin
                    // zero interval or zero ticks saturates at full scale
                    quo_next   = qds_pkg::FULL_VEC;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    if (trial >= den_ext)
                    begin
                        rem_next = qds_pkg::DEN_W'(trial - den_ext);
                        quo_next = {quo_reg[qds_pkg::SPEED_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[qds_pkg::DEN_W-1:0];
                        quo_next = {quo_reg[qds_pkg::SPEED_W-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        ticks_reg   <= ticks_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/qds_checker.sv =====
// ---------------------------------------------------------------------------
// qds_checker
// port-level assertions for the quadrature decoder, bound to the top level
// ---------------------------------------------------------------------------
`include "quadrature_direction_speed_macros.svh"

module qds_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    input  logic                              sample_ready,
    input  logic                              result_valid,
    input  logic                              result_ready,
    input  qds_pkg::result_t                  result
);

    logic [qds_pkg::RPM_W+5:0] rps_x60;
    logic [qds_pkg::RPM_W+5:0] rpm_ext;

    assign rps_x60 = (qds_pkg::RPM_W + 6)'(result.rev_per_sec) * (qds_pkg::RPM_W + 6)'(60);
    assign rpm_ext = (qds_pkg::RPM_W + 6)'(result.rev_per_min);

    // stalled result word holds
    `QDS_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result), "result word changed while stalled")

    // one sample word at a time
    `QDS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, sample_valid && sample_ready,
        !sample_ready, "sample taken while a word is in work")

    // moving means exactly one direction flag
    `QDS_ASSERT_IMP(a_dir_flags, clk, rst_n, result_valid,
        (result.moving == (result.dir_forward ^ result.dir_backward))
        && !(result.dir_forward && result.dir_backward), "direction flags inconsistent")

    // rpm is rps times sixty
    `QDS_ASSERT_IMP(a_rpm_scale, clk, rst_n, result_valid,
        rps_x60 == rpm_ext, "rev_per_min does not match rev_per_sec")

endmodule

bind quadrature_direction_speed qds_checker u_qds_checker (.*);
